// File: hdl/rkd_pkg.sv
// Shared types and constants for the RSA key derivation block.
package rkd_pkg;

  localparam int PRIME_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH     = 32;
  localparam int RESULT_WIDTH    = 64;
  localparam int EXP_WIDTH       = 8;
  localparam int STATUS_WIDTH    = 2;

  localparam logic [EXP_WIDTH-1:0] EXP_RESET = 8'd3;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EQUAL = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_NOINV = 2'd2;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] prime_p;
    logic [FIELD_WIDTH-1:0] prime_q;
  } key_in_t;

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] modulus;
    logic [RESULT_WIDTH-1:0] private_exp;
    logic [STATUS_WIDTH-1:0] status;
  } key_out_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
  } alu_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULN,
    S_MULT,
    S_CHECK,
    S_TEST,
    S_DIV,
    S_UPD,
    S_MAG,
    S_NEG,
    S_DONE
  } rkd_state_t;

endpackage

// File: hdl/rkd_alu.sv
// Shared add/subtract unit used by every Euclid and reduction step.
module rkd_alu import rkd_pkg::*; #(
  parameter int WIDTH = 2 * PRIME_WIDTH_DEF
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  alu_ctrl_t        ctrl,
  output logic [WIDTH-1:0] sum,
  output logic             carry
);

  logic             sub;
  logic [WIDTH-1:0] b_eff;

  assign sub   = (ctrl.op == ALU_SUB);
  assign b_eff = sub ? ~b : b;

  // On subtract, carry high means a >= b.
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (WIDTH + 1)'(sub);

endmodule

// File: hdl/rkd_mul.sv
// Shared multiplier for the modulus and the totient.
module rkd_mul import rkd_pkg::*; #(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic [PRIME_WIDTH-1:0]   a,
  input  logic [PRIME_WIDTH-1:0]   b,
  output logic [2*PRIME_WIDTH-1:0] prod
);

  assign prod = (2 * PRIME_WIDTH)'(a) * (2 * PRIME_WIDTH)'(b);

endmodule

// File: hdl/rkd_core.sv
// Sequencer and datapath: products, extended Euclid and result register.
module rkd_core import rkd_pkg::*; #(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 idle,
  input  key_in_t              item,
  input  logic [EXP_WIDTH-1:0] exp_e,
  output logic                 out_valid,
  input  logic                 out_ready,
  output key_out_t             out_data
);

  localparam int MW = 2 * PRIME_WIDTH;
  localparam int CW = $clog2(MW + 1);

  rkd_state_t state, state_next;

  logic [PRIME_WIDTH-1:0] p, q;
  logic [EXP_WIDTH-1:0]   e;
  logic [MW-1:0]          n, tot;
  logic [MW-1:0]          ra;
  logic [EXP_WIDTH-1:0]   rb;
  logic [MW-1:0]          u0, u1, acc, dsh;
  logic [EXP_WIDTH-1:0]   rem;
  logic [CW-1:0]          cnt;
  logic                   idx, first;
  logic [MW-1:0]          res_d;
  logic [STATUS_WIDTH-1:0] res_status;

  logic [PRIME_WIDTH-1:0] mul_a, mul_b;
  logic [MW-1:0]          prod;
  logic [MW-1:0]          alu_a, alu_b, alu_sum;
  logic                   alu_carry;
  alu_ctrl_t              alu_ctrl;

  logic [EXP_WIDTH:0]     rem_sh;
  logic                   ge;
  logic [EXP_WIDTH-1:0]   rem_step;

  rkd_mul #(.PRIME_WIDTH(PRIME_WIDTH)) u_mul (
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rkd_alu #(.WIDTH(MW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .ctrl  (alu_ctrl),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Restoring division by the 8-bit divisor, one quotient bit a cycle.
  assign rem_sh   = {rem, dsh[MW-1]};
  assign ge       = (rem_sh >= {1'b0, rb});
  assign rem_step = ge ? EXP_WIDTH'(rem_sh - {1'b0, rb}) : rem_sh[EXP_WIDTH-1:0];

  assign mul_a = (state == S_MULN) ? p : p - PRIME_WIDTH'(1);
  assign mul_b = (state == S_MULN) ? q : q - PRIME_WIDTH'(1);

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    alu_ctrl.op = ALU_ADD;
    alu_a       = u0;
    alu_b       = acc;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_MULN;
        end
      end
      S_MULN:  state_next = S_MULT;
      S_MULT:  state_next = S_CHECK;
      S_CHECK: begin
        if (p == q || tot == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (rb != '0) begin
          state_next = S_DIV;
        end else if (ra == MW'(1)) begin
          state_next = S_MAG;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        // Horner accumulation of quotient times u1.
        alu_a = {acc[MW-2:0], 1'b0};
        alu_b = ge ? u1 : '0;
        if (cnt == CW'(1)) begin
          state_next = S_UPD;
        end
      end
      S_UPD:   state_next = S_TEST;
      S_MAG: begin
        alu_ctrl.op = ALU_SUB;
        alu_a       = u0;
        alu_b       = tot;
        state_next  = S_NEG;
      end
      S_NEG: begin
        alu_ctrl.op = ALU_SUB;
        alu_a       = tot;
        alu_b       = u0;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          p <= item.prime_p[PRIME_WIDTH-1:0];
          q <= item.prime_q[PRIME_WIDTH-1:0];
          e <= exp_e;
        end
      end
      S_MULN: n <= prod;
      S_MULT: tot <= prod;
      S_CHECK: begin
        res_d <= '0;
        if (p == q) begin
          res_status <= ST_EQUAL;
          n          <= '0;
        end else if (tot == '0) begin
          res_status <= ST_NOINV;
        end
        ra    <= tot;
        rb    <= e;
        u0    <= '0;
        u1    <= MW'(1);
        idx   <= 1'b0;
        first <= 1'b1;
      end
      S_TEST: begin
        rem <= '0;
        acc <= '0;
        if (first) begin
          dsh <= ra;
          cnt <= CW'(MW);
        end else begin
          dsh <= {ra[EXP_WIDTH-1:0], (MW - EXP_WIDTH)'(0)};
          cnt <= CW'(EXP_WIDTH);
        end
        if (rb == '0) begin
          res_d      <= '0;
          res_status <= ST_NOINV;
        end
      end
      S_DIV: begin
        rem <= rem_step;
        acc <= alu_sum;
        dsh <= {dsh[MW-2:0], 1'b0};
        cnt <= cnt - CW'(1);
      end
      S_UPD: begin
        ra    <= MW'(rb);
        rb    <= rem;
        u0    <= u1;
        u1    <= alu_sum;
        idx   <= ~idx;
        first <= 1'b0;
      end
      S_MAG: begin
        // Reduce the coefficient magnitude modulo the totient.
        if (alu_carry) begin
          u0 <= alu_sum;
        end
      end
      S_NEG: begin
        // Even index means a negative coefficient: add the totient.
        res_status <= ST_OK;
        if (idx || u0 == '0) begin
          res_d <= u0;
        end else begin
          res_d <= alu_sum;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.modulus     <= RESULT_WIDTH'(n);
      out_data.private_exp <= RESULT_WIDTH'(res_d);
      out_data.status      <= res_status;
    end
  end

endmodule

// File: hdl/rsa_key_derivation.sv
// Top level: public exponent register and the key derivation core.
//
// Input channel in_valid/in_ready/in_data carries the primes p and q; only
// the low PRIME_WIDTH bits of each are used. Output channel
// out_valid/out_ready/out_data returns one item per input: modulus n = p*q,
// private exponent d and a status code (ok, primes equal, not invertible).
// The config channel cfg_valid/cfg_ready/cfg_data writes the public
// exponent; it is always ready and should only be written while idle.
// An item goes through the products and checks, then the first Euclid step
// (wide remainder by the 8-bit exponent), then later Euclid steps on 8-bit
// remainders (at most 11), then a final test that sees the zero remainder,
// the reduction and the output register; the reduction is skipped when e
// has no inverse. Equal primes or a zero totient skip Euclid; a zero
// exponent stops at the first test. Each division is bit-serial on the
// shared adder. in_ready is high only while the sequencer is idle, so a new
// item is taken only once the previous one has left the sequencer. A
// finished result sits in the output register; the sequencer accepts the
// next item meanwhile and holds its own result until the register frees
// up. Reset clears the sequencer and output valid and sets the exponent to 3.
module rsa_key_derivation import rkd_pkg::*; #(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  key_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output key_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [EXP_WIDTH-1:0] cfg_data
);

  logic [EXP_WIDTH-1:0] public_exp;
  logic                 idle;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exp <= EXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      public_exp <= cfg_data;
    end
  end

  rkd_core #(.PRIME_WIDTH(PRIME_WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .idle      (idle),
    .item      (in_data),
    .exp_e     (public_exp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
